// ===== rtl/core/bpq_pkg.sv =====
package bpq_pkg;

  localparam int LABEL_W = 12;
  localparam int COST_W = 32;
  localparam int SHIFT_W = 5;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_NUM_BUCKETS = 64;
  localparam int DEF_MAX_LABELS = 4096;

  // Depth of the command queue and of the result queue, powers of two.
  localparam int CQ_DEPTH = 2;
  localparam int RQ_DEPTH = 2;

  localparam logic [COST_W-1:0] COST_SAT = 32'hFFFF_FFFF;

  localparam logic [COST_W-1:0] START_RST = 32'd0;
  localparam logic [COST_W-1:0] RANGE_RST = 32'd16384;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd8;

  // Command codes as they arrive on the input port.
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_DECREASE = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_DECREASE,
    OP_REMOVE,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               lab_ok;
    logic [LABEL_W-1:0] label;
    logic [COST_W-1:0]  sort_cost;
    logic [COST_W-1:0]  prior_cost;
  } cmd_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               found;
  } res_t;

  typedef struct packed {
    logic [COST_W-1:0]  start;
    logic [COST_W-1:0]  range;
    logic [SHIFT_W-1:0] shift;
  } cfg_t;

endpackage

// ===== rtl/core/bpq_front.sv =====
module bpq_front #(
  parameter int MAX_LABELS = bpq_pkg::DEF_MAX_LABELS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  command,
  input  logic [bpq_pkg::LABEL_W-1:0] label,
  input  logic [bpq_pkg::COST_W-1:0]  sort_cost,
  input  logic [bpq_pkg::COST_W-1:0]  prior_cost,
  input  logic                        hold,
  output logic                        cmd_valid,
  output bpq_pkg::cmd_t               cmd,
  input  logic                        cmd_ready
);
  import bpq_pkg::*;

  localparam int PW = $clog2(CQ_DEPTH);

  cmd_t            cq [CQ_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  cmd_t            item;
  logic            wr_en;
  logic            rd_en;

  // Classification: command code to operation, and label range check.
  always_comb begin
    item.label = label;
    item.sort_cost = sort_cost;
    item.prior_cost = prior_cost;
    item.lab_ok = 32'(label) < 32'(MAX_LABELS);
    case (command)
      CMD_ADD:      item.op = OP_ADD;
      CMD_DECREASE: item.op = OP_DECREASE;
      CMD_REMOVE:   item.op = OP_REMOVE;
      CMD_CLEAR:    item.op = OP_CLEAR;
      default:      item.op = OP_CLEAR;
    endcase
  end

  assign full = (count == (PW+1)'(CQ_DEPTH)) || hold;
  assign wr_en = push && !full;
  assign cmd_valid = (count != '0);
  assign rd_en = cmd_valid && cmd_ready;
  assign cmd = cq[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cq[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/bpq_result_q.sv =====
module bpq_result_q (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        res_valid,
  input  bpq_pkg::res_t               res,
  output logic                        res_ready,
  output logic                        empty,
  input  logic                        pop,
  output logic [bpq_pkg::LABEL_W-1:0] out_label,
  output logic                        found
);
  import bpq_pkg::*;

  localparam int PW = $clog2(RQ_DEPTH);

  res_t          rq [RQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          wr_en;
  logic          rd_en;

  assign res_ready = (count != (PW+1)'(RQ_DEPTH));
  assign wr_en = res_valid && res_ready;
  assign empty = (count == '0);
  assign rd_en = pop && !empty;
  assign out_label = rq[rd_ptr].label;
  assign found = rq[rd_ptr].found;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rq[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/bpq_div.sv =====
module bpq_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bpq_pkg::COST_W-1:0] dividend,
  input  logic [bpq_pkg::COST_W-1:0] divisor,
  output logic                       done,
  output logic [bpq_pkg::COST_W-1:0] rem
);
  import bpq_pkg::*;

  localparam int CW = $clog2(COST_W);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [COST_W-1:0] quo;
  logic [COST_W-1:0] dsr;
  logic [COST_W:0]   trial;
  logic              ge;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem, quo[COST_W-1]};
  assign ge = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[COST_W-2:0], ge};
      rem <= ge ? COST_W'(trial - {1'b0, dsr}) : COST_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(COST_W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/bpq_back.sv =====
module bpq_back #(
  parameter int NUM_BUCKETS = bpq_pkg::DEF_NUM_BUCKETS,
  parameter int MAX_LABELS = bpq_pkg::DEF_MAX_LABELS
) (
  input  logic          clk,
  input  logic          rst,
  input  bpq_pkg::cfg_t cfg,
  input  logic          reinit,
  input  logic          cmd_valid,
  input  bpq_pkg::cmd_t cmd,
  output logic          cmd_ready,
  output logic          res_valid,
  output bpq_pkg::res_t res,
  input  logic          res_ready,
  output logic          clearing
);
  import bpq_pkg::*;

  localparam int LABW = $clog2(MAX_LABELS);
  localparam int LW = LABW + 1;
  localparam int LSTW = $clog2(NUM_BUCKETS + 1);
  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int CLR_N = (MAX_LABELS > NUM_BUCKETS + 1) ? MAX_LABELS : NUM_BUCKETS + 1;
  localparam int CLRW = $clog2(CLR_N);
  localparam logic [LW-1:0] NIL = LW'(MAX_LABELS);
  localparam logic [LSTW-1:0] OVF = LSTW'(NUM_BUCKETS);
  localparam logic [LSTW-1:0] LAST_LIST = LSTW'(NUM_BUCKETS - 1);

  typedef enum logic [19:0] {
    S_INIT     = 20'h00001,
    S_CLR      = 20'h00002,
    S_IDLE     = 20'h00004,
    S_LOOK     = 20'h00008,
    S_DECIDE   = 20'h00010,
    S_APP_RD   = 20'h00020,
    S_APP_WR   = 20'h00040,
    S_APP_LINK = 20'h00080,
    S_SCAN_RD  = 20'h00100,
    S_SCAN_CHK = 20'h00200,
    S_POP      = 20'h00400,
    S_OVF_RD   = 20'h00800,
    S_OVF_CHK  = 20'h01000,
    S_MIN_CHK  = 20'h02000,
    S_SLIDE    = 20'h04000,
    S_DIV      = 20'h08000,
    S_SHIFT    = 20'h10000,
    S_RD_RD    = 20'h20000,
    S_RD_CHK   = 20'h40000,
    S_EMIT     = 20'h80000
  } state_t;

  state_t state;

  // Per-label stores and list heads and tails.
  logic [LW-1:0]     next_mem [MAX_LABELS];
  logic [LW-1:0]     prev_mem [MAX_LABELS];
  logic [COST_W-1:0] cost_mem [MAX_LABELS];
  logic [LSTW-1:0]   list_mem [MAX_LABELS];
  logic              inq_mem  [MAX_LABELS];
  logic [LW-1:0]     head_mem [NUM_BUCKETS + 1];
  logic [LW-1:0]     tail_mem [NUM_BUCKETS + 1];

  logic              nx_we, pv_we, cs_we, ls_we, iq_we, hd_we, tl_we;
  logic [LABW-1:0]   nx_wa, pv_wa, cs_wa, ls_wa, iq_wa;
  logic [LSTW-1:0]   hd_wa, tl_wa;
  logic [LW-1:0]     nx_wd, pv_wd, hd_wd, tl_wd;
  logic [COST_W-1:0] cs_wd;
  logic [LSTW-1:0]   ls_wd;
  logic              iq_wd;
  logic [LABW-1:0]   lab_ra;
  logic [LSTW-1:0]   hd_ra;
  logic [LW-1:0]     nx_q, pv_q, hd_q, tl_q;
  logic [COST_W-1:0] cs_q;
  logic [LSTW-1:0]   ls_q;
  logic              iq_q;

  // Sequencer registers.
  logic [CLRW-1:0]   clr_cnt;
  op_t               op_r;
  logic [COST_W-1:0] sc_r;
  logic [COST_W-1:0] pc_r;
  logic [LABW-1:0]   ulab;
  logic [LSTW-1:0]   pl_r;
  logic [LSTW-1:0]   nl_r;
  logic [LSTW-1:0]   app_list;
  logic [LW-1:0]     app_t;
  logic              redist;
  logic              pass2;
  logic              found_r;
  logic [BW-1:0]     scan_b;
  logic [BW-1:0]     cb;
  logic [COST_W-1:0] cc;
  logic [63:0]       wl;
  logic [63:0]       wh;
  logic [COST_W-1:0] m_r;
  logic [LW-1:0]     walk;
  logic [LW-1:0]     ovf_first;
  logic [COST_W-1:0] dvd;
  logic [63:0]       sh;

  logic              do_unlink;
  logic [COST_W-1:0] rng;
  logic [COST_W:0]   cc_sum;
  logic [COST_W-1:0] cc_step;
  logic [63:0]       wl_new;
  logic              far_slide;
  logic              div_start;
  logic              div_done;
  logic [COST_W-1:0] div_rem;
  logic [COST_W-1:0] init_mask;

  function automatic logic [LSTW-1:0] bucket_of(input logic [COST_W-1:0] c);
    logic [COST_W-1:0] d;
    logic [COST_W-1:0] s;
    logic [LSTW-1:0]   idx;
    d = '0;
    if ({32'd0, c} >= wl) d = c - wl[COST_W-1:0];
    s = d >> cfg.shift;
    if (s > 32'(NUM_BUCKETS - 1)) idx = LAST_LIST;
    else idx = LSTW'(s);
    return idx;
  endfunction

  function automatic logic [LSTW-1:0] pick_list(input logic [COST_W-1:0] c);
    logic [LSTW-1:0] l;
    if (c < cc) l = LSTW'(cb);
    else if ({32'd0, c} < wh) l = bucket_of(c);
    else l = OVF;
    return l;
  endfunction

  bpq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (m_r - wh[COST_W-1:0]),
    .divisor  (rng),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign rng = (cfg.range == '0) ? 32'd1 : cfg.range;
  assign cc_sum = {1'b0, cc} + ((COST_W+1)'(1) << cfg.shift);
  assign cc_step = (cc_sum > {1'b0, COST_SAT}) ? COST_SAT : cc_sum[COST_W-1:0];
  assign wl_new = wl + sh;
  assign far_slide = {32'd0, m_r} >= (wh + {32'd0, rng});
  assign div_start = (state == S_SLIDE) && far_slide;
  assign init_mask = (32'd1 << cfg.shift) - 32'd1;

  assign clearing = (state == S_INIT) || (state == S_CLR);
  assign cmd_ready = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);
  assign res.found = found_r;
  assign res.label = found_r ? LABEL_W'(ulab) : '0;

  assign do_unlink = (state == S_POP) ||
                     ((state == S_DECIDE) && iq_q &&
                      ((op_r == OP_ADD) || (pl_r != nl_r)));

  // Read addresses.
  always_comb begin
    case (state)
      S_SCAN_CHK: lab_ra = hd_q[LABW-1:0];
      S_OVF_CHK:  lab_ra = hd_q[LABW-1:0];
      S_MIN_CHK:  lab_ra = nx_q[LABW-1:0];
      S_RD_RD:    lab_ra = walk[LABW-1:0];
      default:    lab_ra = ulab;
    endcase
    hd_ra = (state == S_SCAN_RD) ? LSTW'(scan_b) : OVF;
  end

  // Write ports.
  always_comb begin
    nx_we = 1'b0; nx_wa = ulab; nx_wd = NIL;
    pv_we = 1'b0; pv_wa = ulab; pv_wd = NIL;
    cs_we = 1'b0; cs_wa = ulab; cs_wd = sc_r;
    ls_we = 1'b0; ls_wa = ulab; ls_wd = app_list;
    iq_we = 1'b0; iq_wa = ulab; iq_wd = 1'b0;
    hd_we = 1'b0; hd_wa = app_list; hd_wd = NIL;
    tl_we = 1'b0; tl_wa = app_list; tl_wd = NIL;
    if (do_unlink) begin
      if (pv_q == NIL) begin
        hd_we = 1'b1; hd_wa = ls_q; hd_wd = nx_q;
      end else if (pv_q < NIL) begin
        nx_we = 1'b1; nx_wa = pv_q[LABW-1:0]; nx_wd = nx_q;
      end
      if (nx_q == NIL) begin
        tl_we = 1'b1; tl_wa = ls_q; tl_wd = pv_q;
      end else if (nx_q < NIL) begin
        pv_we = 1'b1; pv_wa = nx_q[LABW-1:0]; pv_wd = pv_q;
      end
      iq_we = 1'b1;
    end
    case (state)
      S_CLR: begin
        iq_we = 32'(clr_cnt) < 32'(MAX_LABELS);
        iq_wa = clr_cnt[LABW-1:0];
        hd_we = 32'(clr_cnt) <= 32'(NUM_BUCKETS);
        hd_wa = clr_cnt[LSTW-1:0];
        tl_we = hd_we;
        tl_wa = clr_cnt[LSTW-1:0];
      end
      S_DECIDE: begin
        cs_we = 1'b1;
      end
      S_APP_WR: begin
        nx_we = 1'b1;
        pv_we = 1'b1; pv_wd = tl_q;
        tl_we = 1'b1; tl_wd = LW'(ulab);
        ls_we = 1'b1;
        iq_we = 1'b1; iq_wd = 1'b1;
        hd_we = (tl_q == NIL); hd_wd = LW'(ulab);
      end
      S_APP_LINK: begin
        nx_we = 1'b1; nx_wa = app_t[LABW-1:0]; nx_wd = LW'(ulab);
      end
      S_SHIFT: begin
        hd_we = 1'b1; hd_wa = OVF;
        tl_we = 1'b1; tl_wa = OVF;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    nx_q <= next_mem[lab_ra];
  end

  always_ff @(posedge clk) begin
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    pv_q <= prev_mem[lab_ra];
  end

  always_ff @(posedge clk) begin
    if (cs_we) cost_mem[cs_wa] <= cs_wd;
    cs_q <= cost_mem[lab_ra];
  end

  always_ff @(posedge clk) begin
    if (ls_we) list_mem[ls_wa] <= ls_wd;
    ls_q <= list_mem[lab_ra];
  end

  always_ff @(posedge clk) begin
    if (iq_we) inq_mem[iq_wa] <= iq_wd;
    iq_q <= inq_mem[lab_ra];
  end

  always_ff @(posedge clk) begin
    if (hd_we) head_mem[hd_wa] <= hd_wd;
    hd_q <= head_mem[hd_ra];
  end

  always_ff @(posedge clk) begin
    if (tl_we) tail_mem[tl_wa] <= tl_wd;
    tl_q <= tail_mem[app_list];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else if (reinit) begin
      state <= S_INIT;
    end else begin
      case (state)
        S_INIT: begin
          wl <= {32'd0, cfg.start & ~init_mask};
          wh <= {32'd0, cfg.start} + {32'd0, cfg.range};
          cc <= cfg.start & ~init_mask;
          cb <= '0;
          clr_cnt <= '0;
          state <= S_CLR;
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLRW'(CLR_N - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            op_r <= cmd.op;
            sc_r <= cmd.sort_cost;
            pc_r <= cmd.prior_cost;
            ulab <= LABW'(cmd.label);
            redist <= 1'b0;
            pass2 <= 1'b0;
            case (cmd.op)
              OP_ADD, OP_DECREASE: begin
                if (cmd.lab_ok) begin
                  state <= S_LOOK;
                end
              end
              OP_REMOVE: begin
                scan_b <= cb;
                state <= S_SCAN_RD;
              end
              OP_CLEAR: begin
                cb <= '0;
                cc <= (wl > {32'd0, COST_SAT}) ? COST_SAT : wl[COST_W-1:0];
                clr_cnt <= '0;
                state <= S_CLR;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_LOOK: begin
          nl_r <= pick_list(sc_r);
          pl_r <= pick_list(pc_r);
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          app_list <= nl_r;
          if ((op_r == OP_ADD) || (pl_r != nl_r)) begin
            state <= S_APP_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_APP_RD: begin
          state <= S_APP_WR;
        end
        S_APP_WR: begin
          app_t <= tl_q;
          if (tl_q != NIL) begin
            state <= S_APP_LINK;
          end else begin
            state <= redist ? S_RD_RD : S_IDLE;
          end
        end
        S_APP_LINK: begin
          state <= redist ? S_RD_RD : S_IDLE;
        end
        S_SCAN_RD: begin
          cb <= scan_b;
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (hd_q < NIL) begin
            ulab <= hd_q[LABW-1:0];
            state <= S_POP;
          end else begin
            cc <= cc_step;
            if (scan_b == BW'(NUM_BUCKETS - 1)) begin
              if (pass2) begin
                found_r <= 1'b0;
                state <= S_EMIT;
              end else begin
                state <= S_OVF_RD;
              end
            end else begin
              scan_b <= scan_b + 1'b1;
              state <= S_SCAN_RD;
            end
          end
        end
        S_POP: begin
          found_r <= 1'b1;
          state <= S_EMIT;
        end
        S_OVF_RD: begin
          state <= S_OVF_CHK;
        end
        S_OVF_CHK: begin
          if (hd_q < NIL) begin
            ovf_first <= hd_q;
            m_r <= COST_SAT;
            state <= S_MIN_CHK;
          end else begin
            found_r <= 1'b0;
            state <= S_EMIT;
          end
        end
        S_MIN_CHK: begin
          if (cs_q < m_r) begin
            m_r <= cs_q;
          end
          if (!(nx_q < NIL)) begin
            state <= S_SLIDE;
          end
        end
        S_SLIDE: begin
          dvd <= m_r - wh[COST_W-1:0];
          sh <= {32'd0, rng};
          state <= far_slide ? S_DIV : S_SHIFT;
        end
        S_DIV: begin
          if (div_done) begin
            sh <= {32'd0, dvd - div_rem} + {32'd0, rng};
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          wl <= wl_new;
          wh <= wh + sh;
          cc <= (wl_new > {32'd0, COST_SAT}) ? COST_SAT : wl_new[COST_W-1:0];
          walk <= ovf_first;
          state <= S_RD_RD;
        end
        S_RD_RD: begin
          if (walk < NIL) begin
            state <= S_RD_CHK;
          end else begin
            scan_b <= '0;
            pass2 <= 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_RD_CHK: begin
          ulab <= walk[LABW-1:0];
          walk <= nx_q;
          app_list <= ({32'd0, cs_q} < wh) ? bucket_of(cs_q) : OVF;
          redist <= 1'b1;
          state <= S_APP_RD;
        end
        S_EMIT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/bucketed_priority_queue_top.sv =====
// Channel   Direction  Handshake             Word
// input     in         push / full           command, label, sort_cost, prior_cost
// result    out        empty / pop           out_label, found
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Add and decrease wait on the list memories' registered reads in the back
// sequencer; a decrease that keeps its list skips the append. Remove scans the
// buckets in turn; when the buckets run dry, the overflow list is walked once
// for its minimum, a restoring divider may run to size the window slide, and
// each overflow word is then re-bucketed.
// Reset, every write to one of the three registers and every clear command
// start a clearing pass over max(MAX_LABELS, NUM_BUCKETS + 1) addresses (4096
// by default); full is held high during it. A two-word command queue lets
// input words be taken while the back works, and a two-word result queue lets
// it finish while the result side stalls.
module bucketed_priority_queue_top #(
  parameter int NUM_BUCKETS = bpq_pkg::DEF_NUM_BUCKETS,
  parameter int MAX_LABELS = bpq_pkg::DEF_MAX_LABELS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    command,
  input  logic [bpq_pkg::LABEL_W-1:0]   label,
  input  logic [bpq_pkg::COST_W-1:0]    sort_cost,
  input  logic [bpq_pkg::COST_W-1:0]    prior_cost,
  output logic                          empty,
  input  logic                          pop,
  output logic [bpq_pkg::LABEL_W-1:0]   out_label,
  output logic                          found,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpq_pkg::COST_W-1:0]    cfg_data
);
  import bpq_pkg::*;

  cfg_t  cfg;
  logic  cfg_hit;
  logic  clearing;
  logic  cmd_valid;
  logic  cmd_ready;
  cmd_t  cmd;
  logic  res_valid;
  logic  res_ready;
  res_t  res;

  // The configuration port is always ready. A write to one of the three
  // registers rebuilds the window and empties every list; any other index is
  // taken and dropped.
  assign cfg_ready = 1'b1;
  assign cfg_hit = cfg_valid && cfg_ready &&
                   ((cfg_index == CFG_START) || (cfg_index == CFG_RANGE) ||
                    (cfg_index == CFG_SHIFT));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start <= START_RST;
      cfg.range <= RANGE_RST;
      cfg.shift <= SHIFT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START: cfg.start <= cfg_data;
        CFG_RANGE: cfg.range <= cfg_data;
        CFG_SHIFT: cfg.shift <= cfg_data[SHIFT_W-1:0];
        default:   cfg.start <= cfg.start;
      endcase
    end
  end

  // The front takes words, decodes them and checks the label range.
  bpq_front #(
    .MAX_LABELS (MAX_LABELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .command    (command),
    .label      (label),
    .sort_cost  (sort_cost),
    .prior_cost (prior_cost),
    .hold       (clearing),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_ready  (cmd_ready)
  );

  // The back owns the list memories and the window, and carries out one
  // command at a time.
  bpq_back #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .MAX_LABELS  (MAX_LABELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .reinit    (cfg_hit),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .clearing  (clearing)
  );

  bpq_result_q u_result_q (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .empty     (empty),
    .pop       (pop),
    .out_label (out_label),
    .found     (found)
  );

  // A not-found result always carries label zero.
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !found) |-> (out_label == '0))
    else $error("not-found result with a non-zero label");

  // Reset starts the clearing pass.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> clearing)
    else $error("no clearing pass after reset");

  // A register write starts the clearing pass.
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> clearing)
    else $error("no clearing pass after a configuration write");

  // The back never offers a result while it is still clearing.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !res_valid)
    else $error("result offered during the clearing pass");

endmodule

// ===== tb/sv/bucketed_priority_queue_top_tb.sv =====
module bucketed_priority_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpq_pkg::*;

  localparam int NB = DEF_NUM_BUCKETS;
  localparam int NL = DEF_MAX_LABELS;
  localparam int OVF = NB;
  localparam int NIL = NL;
  localparam longint unsigned SAT64 = 64'h0000_0000_FFFF_FFFF;

  // Number of cycles allowed for the block to settle after the last result:
  // enough for a clearing pass in the back and two more queued behind it.
  localparam int SETTLE = 13000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [1:0]           command = CMD_ADD;
  logic [LABEL_W-1:0]   label = '0;
  logic [COST_W-1:0]    sort_cost = '0;
  logic [COST_W-1:0]    prior_cost = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [LABEL_W-1:0]   out_label;
  logic                 found;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_START;
  logic [COST_W-1:0]    cfg_data = '0;

  bucketed_priority_queue_top u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .label(label), .sort_cost(sort_cost), .prior_cost(prior_cost),
    .empty(empty), .pop(pop), .out_label(out_label), .found(found),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // The clock has a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Shadow of the queue. Every list is a doubly linked chain of labels held in
  // per-label arrays; the overflow list sits after the regular buckets.
  // -------------------------------------------------------------------------
  logic [COST_W-1:0]  reg_start;
  logic [COST_W-1:0]  reg_range;
  logic [SHIFT_W-1:0] reg_shift;

  int                 link_next [NL];
  int                 link_prev [NL];
  logic [COST_W-1:0]  cost_of [NL];
  int                 list_of [NL];
  bit                 queued [NL];
  int                 head [NB+1];
  int                 tail [NB+1];
  int                 cur_bucket;
  longint unsigned    cur_cost;
  longint unsigned    win_low;
  longint unsigned    win_high;

  res_t               removals_due [$];
  int                 failures = 0;
  int                 words_taken = 0;
  bit                 steady = 1'b0;

  function automatic void empty_lists();
    for (int i = 0; i <= NB; i++) begin
      head[i] = NIL;
      tail[i] = NIL;
    end
    for (int i = 0; i < NL; i++) queued[i] = 1'b0;
    cur_bucket = 0;
  endfunction

  function automatic void rebuild_window();
    longint unsigned mask;
    mask = (64'd1 << reg_shift) - 1;
    empty_lists();
    win_low = longint'(reg_start) & ~mask;
    win_high = longint'(reg_start) + longint'(reg_range);
    cur_cost = win_low;
  endfunction

  function automatic int bucket_for(longint unsigned c);
    longint unsigned idx;
    idx = 0;
    if (c >= win_low) idx = (c - win_low) >> reg_shift;
    if (idx > NB - 1) idx = NB - 1;
    return int'(idx);
  endfunction

  function automatic int list_for(longint unsigned c);
    if (c < cur_cost) return cur_bucket;
    if (c < win_high) return bucket_for(c);
    return OVF;
  endfunction

  function automatic void append_to(int l, int lab);
    int t;
    t = tail[l];
    link_next[lab] = NIL;
    link_prev[lab] = t;
    if (t == NIL) head[l] = lab;
    else link_next[t] = lab;
    tail[l] = lab;
    list_of[lab] = l;
    queued[lab] = 1'b1;
  endfunction

  function automatic void detach(int lab);
    int l;
    int p;
    int n;
    l = list_of[lab];
    p = link_prev[lab];
    n = link_next[lab];
    if (p == NIL) head[l] = n;
    else link_next[p] = n;
    if (n == NIL) tail[l] = p;
    else link_prev[n] = p;
    queued[lab] = 1'b0;
  endfunction

  // Moves the window up by whole ranges until the cheapest overflow label
  // falls inside it, then re-files every overflow label by its stored cost.
  function automatic void slide_window();
    longint unsigned r;
    longint unsigned k;
    longint unsigned m;
    int lab;
    int nx;
    r = (reg_range == 0) ? 64'd1 : longint'(reg_range);
    k = 1;
    m = SAT64;
    for (lab = head[OVF]; lab != NIL; lab = link_next[lab])
      if (cost_of[lab] < m) m = cost_of[lab];
    if (m >= win_high + r) k = (m - win_high) / r + 1;
    win_low += k * r;
    win_high += k * r;
    cur_cost = (win_low > SAT64) ? SAT64 : win_low;
    lab = head[OVF];
    head[OVF] = NIL;
    tail[OVF] = NIL;
    while (lab != NIL) begin
      nx = link_next[lab];
      if (longint'(cost_of[lab]) < win_high) append_to(bucket_for(cost_of[lab]), lab);
      else append_to(OVF, lab);
      lab = nx;
    end
  endfunction

  function automatic bit scan_buckets(int b, output int lab);
    longint unsigned w;
    w = 64'd1 << reg_shift;
    lab = 0;
    for (; b < NB; b++) begin
      cur_bucket = b;
      if (head[b] != NIL) begin
        lab = head[b];
        detach(lab);
        return 1'b1;
      end
      cur_cost += w;
      if (cur_cost > SAT64) cur_cost = SAT64;
    end
    cur_bucket = NB - 1;
    return 1'b0;
  endfunction

  function automatic res_t take_cheapest();
    res_t r;
    int lab;
    bit hit;
    hit = scan_buckets(cur_bucket, lab);
    if (!hit && head[OVF] != NIL) begin
      slide_window();
      hit = scan_buckets(0, lab);
    end
    r.found = hit;
    r.label = hit ? LABEL_W'(lab) : '0;
    return r;
  endfunction

  // Applies one accepted word to the shadow; returns 1 with the removal that
  // the block owes when the word is a remove.
  function automatic bit apply_word(logic [1:0] cmd, int lab, logic [COST_W-1:0] sc,
                                    logic [COST_W-1:0] pc, output res_t r);
    int from;
    int dest;
    r = '0;
    case (cmd)
      CMD_ADD: begin
        if (queued[lab]) detach(lab);
        cost_of[lab] = sc;
        append_to(list_for(sc), lab);
      end
      CMD_DECREASE: begin
        from = list_for(pc);
        dest = list_for(sc);
        cost_of[lab] = sc;
        if (from != dest) begin
          if (queued[lab]) detach(lab);
          append_to(dest, lab);
        end
      end
      CMD_REMOVE: begin
        r = take_cheapest();
        return 1'b1;
      end
      default: begin
        empty_lists();
        cur_cost = (win_low > SAT64) ? SAT64 : win_low;
      end
    endcase
    return 1'b0;
  endfunction

  // -------------------------------------------------------------------------
  // Gaps: none while steady; otherwise half of them none, most of the rest short, a few long.
  // -------------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offers one word and holds it until the block takes it. Push is only
  // lowered when a gap follows, so a back-to-back word never drops it.
  task automatic send_word(logic [1:0] cmd, int lab, logic [COST_W-1:0] sc,
                           logic [COST_W-1:0] pc, bit typed, res_t typed_res);
    int g;
    res_t r;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push <= 1'b1;
    command <= cmd;
    label <= LABEL_W'(lab);
    sort_cost <= sc;
    prior_cost <= pc;
    do @(posedge clk); while (full);
    words_taken++;
    if (apply_word(cmd, lab, sc, pc, r)) begin
      if (typed && r !== typed_res) begin
        $display("%0t: shadow disagrees with the table: expected %0h/%0b, shadow %0h/%0b",
                 $time, typed_res.label, typed_res.found, r.label, r.found);
        failures++;
      end
      removals_due = {removals_due, (typed ? typed_res : r)};
    end
  endtask

  // Waits until every owed removal has come out and the block has had time to
  // finish any word that produces nothing.
  task automatic drain();
    push <= 1'b0;
    while (removals_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Valid stays high between writes; the caller lowers it after the last one.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COST_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_START: reg_start = val;
      CFG_RANGE: reg_range = val;
      default:   reg_shift = SHIFT_W'(val);
    endcase
    rebuild_window();
  endtask

  task automatic set_window(logic [COST_W-1:0] st, logic [COST_W-1:0] rg,
                            logic [SHIFT_W-1:0] sh);
    drain();
    write_reg(CFG_START, st);
    write_reg(CFG_RANGE, rg);
    write_reg(CFG_SHIFT, COST_W'(sh));
    cfg_valid <= 1'b0;
  endtask

  // Costs cluster around the live window so that buckets, the current bucket
  // and the overflow list are all exercised; some are drawn from the full span.
  function automatic logic [COST_W-1:0] pick_cost();
    longint unsigned span;
    longint unsigned c;
    if ($urandom_range(9) == 0) return $urandom;
    span = 2 * ((reg_range == 0) ? 64'd1 : longint'(reg_range));
    c = win_low + (longint'($urandom) % span);
    return (c > SAT64) ? COST_W'(SAT64) : COST_W'(c);
  endfunction

  function automatic int pick_label();
    if ($urandom_range(19) == 0) return $urandom_range(NL - 1);
    return $urandom_range(47);
  endfunction

  task automatic random_words(int n);
    int r;
    int lab;
    logic [COST_W-1:0] pc;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      lab = pick_label();
      if (r < 40) begin
        send_word(CMD_ADD, lab, pick_cost(), $urandom, 1'b0, '0);
      end else if (r < 60) begin
        // Usually the true previous cost, sometimes an arbitrary one.
        pc = ($urandom_range(3) == 0) ? pick_cost() : cost_of[lab];
        send_word(CMD_DECREASE, lab, pick_cost(), pc, 1'b0, '0);
      end else if (r < 98) begin
        send_word(CMD_REMOVE, lab, $urandom, $urandom, 1'b0, '0);
      end else begin
        send_word(CMD_CLEAR, lab, $urandom, $urandom, 1'b0, '0);
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Directed table: an empty remove, both label extremes, both cost extremes,
  // the overflow list with a window slide, a re-add of a queued label, a
  // decrease that changes list and one that does not, and two clears.
  // -------------------------------------------------------------------------
  typedef struct {
    logic [1:0]        cmd;
    int                lab;
    logic [COST_W-1:0] sc;
    logic [COST_W-1:0] pc;
    bit                typed;
    res_t              res;
  } row_t;

  localparam res_t NONE = '{label: '0, found: 1'b0};

  row_t plan [] = '{
    '{CMD_REMOVE,   0,    32'h0,         32'h0,        1'b1, NONE},
    '{CMD_ADD,      4095, 32'h0,         32'hFFFFFFFF, 1'b0, NONE},
    '{CMD_ADD,      0,    32'hFFFFFFFF,  32'h0,        1'b0, NONE},
    '{CMD_REMOVE,   0,    32'h0,         32'h0,        1'b1, '{label: 12'hFFF, found: 1'b1}},
    '{CMD_REMOVE,   0,    32'h0,         32'h0,        1'b1, '{label: 12'h000, found: 1'b1}},
    '{CMD_REMOVE,   0,    32'h0,         32'h0,        1'b1, NONE},
    '{CMD_CLEAR,    0,    32'h0,         32'h0,        1'b0, NONE},
    '{CMD_ADD,      5,    32'h0000_0300, 32'h0,        1'b0, NONE},
    '{CMD_ADD,      6,    32'h0000_0310, 32'h0,        1'b0, NONE},
    '{CMD_ADD,      5,    32'h0000_0320, 32'h0,        1'b0, NONE},
    '{CMD_DECREASE, 6,    32'h0000_0100, 32'h0000_0310, 1'b0, NONE},
    '{CMD_DECREASE, 5,    32'h0000_0330, 32'h0000_0320, 1'b0, NONE},
    '{CMD_ADD,      7,    32'h0001_2000, 32'h0,        1'b0, NONE},
    '{CMD_REMOVE,   0,    32'h0,         32'h0,        1'b0, NONE},
    '{CMD_REMOVE,   0,    32'h0,         32'h0,        1'b0, NONE},
    '{CMD_ADD,      9,    32'h0000_0010, 32'h0,        1'b0, NONE},
    '{CMD_REMOVE,   0,    32'h0,         32'h0,        1'b0, NONE},
    '{CMD_REMOVE,   0,    32'h0,         32'h0,        1'b0, NONE},
    '{CMD_CLEAR,    0,    32'h0,         32'h0,        1'b0, NONE},
    '{CMD_REMOVE,   0,    32'h0,         32'h0,        1'b1, NONE}
  };

  // -------------------------------------------------------------------------
  // Result side: checks each removal taken and chooses pop for the next
  // cycle. Once, early in the random part, it refuses to pop for a long
  // stretch so that both small queues fill and the block pushes back.
  // -------------------------------------------------------------------------
  initial begin
    int hold;
    bit held_once;
    res_t want;
    hold = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (removals_due.size() == 0) begin
          $display("%0t: removal %0h/%0b with none owed", $time, out_label, found);
          failures++;
        end else begin
          want = removals_due[0];
          removals_due.delete(0);
          if (out_label !== want.label) begin
            $display("%0t: out_label expected %0h, got %0h", $time, want.label, out_label);
            failures++;
          end
          if (found !== want.found) begin
            $display("%0t: found expected %0b, got %0b", $time, want.found, found);
            failures++;
          end
        end
      end
      if (!held_once && words_taken >= 80) begin
        held_once = 1'b1;
        hold = 600;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (hold < 0) begin
        hold++;
        pop <= 1'b0;
      end else if (gap_len() > 0) begin
        // A random stall, counted down in the same way as the long hold.
        hold = -$urandom_range(8, 1);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence: reset, the directed table at the reset settings, then the
  // random part across several window settings, the extremes among them.
  // -------------------------------------------------------------------------
  initial begin
    reg_start = START_RST;
    reg_range = RANGE_RST;
    reg_shift = SHIFT_RST;
    for (int i = 0; i < NL; i++) begin
      link_next[i] = NIL;
      link_prev[i] = NIL;
      cost_of[i] = '0;
      list_of[i] = 0;
    end
    rebuild_window();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      send_word(plan[i].cmd, plan[i].lab, plan[i].sc, plan[i].pc, plan[i].typed, plan[i].res);

    random_words(140);

    // A narrow window with fine buckets, fed without any idling.
    set_window(32'd1000, 32'd4096, 5'd6);
    steady = 1'b1;
    random_words(110);
    steady = 1'b0;

    // The top of the cost range, the widest window and the widest buckets.
    set_window(32'hFFFF_FF00, 32'hFFFF_FFFF, 5'd31);
    random_words(100);

    // A zero range, which behaves as a range of one, with unit buckets.
    set_window(32'd0, 32'd0, 5'd0);
    random_words(110);

    set_window(32'd12345, 32'd16384, 5'd8);
    random_words(140);

    drain();
    if (failures == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bpq_pkg.sv
rtl/core/bpq_front.sv
rtl/core/bpq_result_q.sv
rtl/core/bpq_div.sv
rtl/core/bpq_back.sv
rtl/core/bucketed_priority_queue_top.sv
tb/sv/bucketed_priority_queue_top_tb.sv
